FILE: hw/rtl/l4cs_pkg.sv
// Shared constants, types and helper functions of the inner L4 checksum engine.
package l4cs_pkg;

    localparam int BYTE_W     = 8;
    localparam int HEADROOM_W = 8;
    localparam int POS_W      = 17;
    localparam int CNT_W      = POS_W + 1;
    localparam int WORD_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int IHL_W      = 4;
    localparam int STATUS_W   = 3;

    localparam logic [WORD_W-1:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]        PROTO_TCP  = 8'd6;
    localparam logic [7:0]        PROTO_UDP  = 8'd17;
    localparam logic [IHL_W-1:0]  IHL_MIN    = 4'd5;
    localparam logic [POS_W-1:0]  POS_MAX    = '1;

    // Byte offsets within the Ethernet and IPv4 headers
    localparam int ETYPE_OFF    = 12;
    localparam int ETH_HDR_LEN  = 14;
    localparam int IP_TLEN_OFF  = 2;
    localparam int IP_PROTO_OFF = 9;
    localparam int IP_SRC_OFF   = 12;
    localparam int IP_DST_OFF   = 16;
    localparam int IP_MIN_LEN   = 20;
    localparam int TCP_MIN_LEN  = 20;
    localparam int UDP_MIN_LEN  = 8;
    localparam int TCP_CSUM_OFF = 16;
    localparam int UDP_CSUM_OFF = 6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOT_IPV4 = 3'd1,
        ST_NOT_L4   = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    // Frame state captured on the last byte, handed to the finishing stage
    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic [HEADROOM_W-1:0] headroom;
        logic [WORD_W-1:0]     ether_type;
        logic [IHL_W-1:0]      hdr_words;
        logic [IHL_W-1:0]      hdr_words_prev;
        logic [WORD_W-1:0]     total_len;
        logic [7:0]            proto;
        logic [ADDR_W-1:0]     src_addr;
        logic [ADDR_W-1:0]     dst_addr;
        logic [WORD_W-1:0]     sum;
        logic [BYTE_W-1:0]     hold;
    } t_snap;

    // Ones'-complement add of two 16-bit words with end-around carry
    function automatic logic [WORD_W-1:0] csum_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

FILE: hw/rtl/l4cs_in_if.sv
// Frame byte channel: valid, ready and one frame byte with its last flag.
interface l4cs_in_if;
    import l4cs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

FILE: hw/rtl/l4cs_out_if.sv
// Result channel: valid, ready and the checksum, its field offset and a status.
interface l4cs_out_if;
    import l4cs_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   checksum_value;
    logic [WORD_W-1:0]   checksum_offset;
    logic [STATUS_W-1:0] result_status;

    modport source (output valid, output checksum_value, output checksum_offset,
                    output result_status, input ready);
    modport sink   (input valid, input checksum_value, input checksum_offset,
                    input result_status, output ready);
endinterface

FILE: hw/rtl/l4cs_parse.sv
// Byte parser: input register, header field capture and running L4 sum.
module l4cs_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    l4cs_in_if.sink                       i_frame,
    input  logic                          i_cfg_we,
    input  logic [l4cs_pkg::HEADROOM_W-1:0] i_cfg_wdata,
    output logic                          o_snap_valid,
    input  logic                          i_snap_ready,
    output l4cs_pkg::t_snap               o_snap
);
    import l4cs_pkg::*;

    logic [HEADROOM_W-1:0] r_headroom;
    logic                  r_a_valid;
    logic [BYTE_W-1:0]     r_a_byte;
    logic                  r_a_last;

    logic [POS_W-1:0]      r_pos;
    logic [WORD_W-1:0]     r_etype;
    logic [IHL_W-1:0]      r_hw;
    logic [WORD_W-1:0]     r_tl;
    logic [7:0]            r_proto;
    logic [ADDR_W-1:0]     r_src;
    logic [ADDR_W-1:0]     r_dst;
    logic [WORD_W-1:0]     r_sum;
    logic [BYTE_W-1:0]     r_hold;

    logic                  r_s_valid;
    t_snap                 r_snap;

    logic [WORD_W-1:0]     n_etype;
    logic [IHL_W-1:0]      n_hw;
    logic [WORD_W-1:0]     n_tl;
    logic [7:0]            n_proto;
    logic [ADDR_W-1:0]     n_src;
    logic [ADDR_W-1:0]     n_dst;
    logic [WORD_W-1:0]     n_sum;
    logic [BYTE_W-1:0]     n_hold;

    logic [POS_W-1:0]      hr;
    logic [POS_W-1:0]      ip0;
    logic [POS_W-1:0]      l4_start;
    logic [POS_W-1:0]      csum_pos;
    logic                  is_l4;
    logic                  sum_en;
    logic                  even_byte;
    logic [BYTE_W-1:0]     sum_byte;
    logic                  a_go;
    logic                  s_load;

    // A non-last byte always advances; a last byte needs room in the snapshot
    assign a_go          = r_a_valid && (!r_a_last || !r_s_valid || i_snap_ready);
    assign s_load        = a_go && r_a_last;
    assign i_frame.ready = !r_a_valid || a_go;
    assign o_snap_valid  = r_s_valid;
    assign o_snap        = r_snap;

    assign hr       = POS_W'(r_headroom);
    assign ip0      = hr + POS_W'(ETH_HDR_LEN);
    // The segment start uses the header length held before this byte
    assign l4_start = ip0 + POS_W'({r_hw, 2'b00});

    always_comb begin
        n_etype = r_etype;
        n_hw    = r_hw;
        n_tl    = r_tl;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        if (r_pos == hr + POS_W'(ETYPE_OFF) || r_pos == hr + POS_W'(ETYPE_OFF + 1)) begin
            n_etype = {r_etype[BYTE_W-1:0], r_a_byte};
        end
        if (r_pos == ip0) begin
            n_hw = r_a_byte[IHL_W-1:0];
        end
        if (r_pos == ip0 + POS_W'(IP_TLEN_OFF) || r_pos == ip0 + POS_W'(IP_TLEN_OFF + 1)) begin
            n_tl = {r_tl[BYTE_W-1:0], r_a_byte};
        end
        if (r_pos == ip0 + POS_W'(IP_PROTO_OFF)) begin
            n_proto = r_a_byte;
        end
        if (r_pos >= ip0 + POS_W'(IP_SRC_OFF) && r_pos < ip0 + POS_W'(IP_DST_OFF)) begin
            n_src = {r_src[ADDR_W-BYTE_W-1:0], r_a_byte};
        end
        if (r_pos >= ip0 + POS_W'(IP_DST_OFF) && r_pos < ip0 + POS_W'(IP_MIN_LEN)) begin
            n_dst = {r_dst[ADDR_W-BYTE_W-1:0], r_a_byte};
        end
    end

    assign is_l4    = (n_proto == PROTO_TCP) || (n_proto == PROTO_UDP);
    assign csum_pos = l4_start + ((n_proto == PROTO_TCP) ? POS_W'(TCP_CSUM_OFF)
                                                         : POS_W'(UDP_CSUM_OFF));
    assign sum_en   = (n_etype == ETYPE_IPV4) && (n_hw >= IHL_MIN) &&
                      (r_pos >= l4_start) && (r_pos < ip0 + POS_W'(n_tl));
    assign even_byte = (r_pos[0] ^ l4_start[0]) == 1'b0;
    // Read the checksum field itself as zero
    assign sum_byte = (is_l4 && (r_pos == csum_pos || r_pos == csum_pos + POS_W'(1)))
                      ? '0 : r_a_byte;

    always_comb begin
        n_hold = r_hold;
        n_sum  = r_sum;
        if (sum_en && even_byte) begin
            n_hold = sum_byte;
        end
        if (sum_en && !even_byte) begin
            n_sum = csum_add(r_sum, {r_hold, sum_byte});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_headroom <= '0;
        end else if (i_cfg_we) begin
            r_headroom <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_a_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_a_byte <= i_frame.frame_byte;
            r_a_last <= i_frame.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s_load) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_hw    <= '0;
            r_tl    <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sum   <= '0;
            r_hold  <= '0;
        end else if (a_go) begin
            if (r_pos != POS_MAX) begin
                r_pos <= r_pos + POS_W'(1);
            end
            r_etype <= n_etype;
            r_hw    <= n_hw;
            r_tl    <= n_tl;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sum   <= n_sum;
            r_hold  <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s_load) begin
            r_s_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_snap.count          <= CNT_W'(r_pos) + CNT_W'(1);
            r_snap.headroom       <= r_headroom;
            r_snap.ether_type     <= n_etype;
            r_snap.hdr_words      <= n_hw;
            r_snap.hdr_words_prev <= r_hw;
            r_snap.total_len      <= n_tl;
            r_snap.proto          <= n_proto;
            r_snap.src_addr       <= n_src;
            r_snap.dst_addr       <= n_dst;
            r_snap.sum            <= n_sum;
            r_snap.hold           <= n_hold;
        end
    end

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load |=> r_pos == '0)
        else $error("byte position not cleared after last byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go && !r_a_last && r_pos != POS_MAX |=> r_pos == $past(r_pos) + POS_W'(1))
        else $error("byte position did not advance");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && !i_snap_ready |-> !s_load)
        else $error("snapshot overwritten while pending");

endmodule

FILE: hw/rtl/l4cs_final.sv
// Finishing stage: status checks, pseudo-header fold and output register.
module l4cs_final (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_snap_valid,
    output logic            o_snap_ready,
    input  l4cs_pkg::t_snap i_snap,
    l4cs_out_if.source      o_result
);
    import l4cs_pkg::*;

    logic                r_o_valid;
    logic [WORD_W-1:0]   r_o_value;
    logic [WORD_W-1:0]   r_o_offset;
    t_status             r_o_status;

    logic [CNT_W-1:0]    ip0;
    logic [WORD_W:0]     hlen_prev;
    logic [WORD_W:0]     l4_min;
    logic                is_tcp;
    logic                is_udp;
    t_status             status;
    logic [WORD_W-1:0]   seg_len;
    logic [WORD_W-1:0]   sum_pad;
    logic [WORD_W+2:0]   total;
    logic [WORD_W:0]     fold1;
    logic [WORD_W-1:0]   fold2;
    logic [WORD_W-1:0]   csum;
    logic [WORD_W-1:0]   offset;
    logic                take;

    assign o_snap_ready = !r_o_valid || o_result.ready;
    assign take         = i_snap_valid && o_snap_ready;

    assign ip0       = CNT_W'(i_snap.headroom) + CNT_W'(ETH_HDR_LEN);
    assign hlen_prev = (WORD_W+1)'({i_snap.hdr_words_prev, 2'b00});
    assign is_tcp    = i_snap.proto == PROTO_TCP;
    assign is_udp    = i_snap.proto == PROTO_UDP;
    assign l4_min    = hlen_prev + (is_tcp ? (WORD_W+1)'(TCP_MIN_LEN)
                                           : (WORD_W+1)'(UDP_MIN_LEN));

    // Checks in order of precedence
    always_comb begin
        if (i_snap.count < ip0) begin
            status = ST_TRUNC;
        end else if (i_snap.ether_type != ETYPE_IPV4) begin
            status = ST_NOT_IPV4;
        end else if (i_snap.count < ip0 + CNT_W'(IP_PROTO_OFF + 1)) begin
            status = ST_TRUNC;
        end else if (!is_tcp && !is_udp) begin
            status = ST_NOT_L4;
        end else if (i_snap.count < ip0 + CNT_W'(IP_MIN_LEN)) begin
            status = ST_TRUNC;
        end else if (i_snap.hdr_words < IHL_MIN ||
                     (WORD_W+1)'(i_snap.total_len) < l4_min) begin
            status = ST_BAD_LEN;
        end else if (i_snap.count < ip0 + CNT_W'(i_snap.total_len)) begin
            status = ST_TRUNC;
        end else begin
            status = ST_OK;
        end
    end

    assign seg_len = i_snap.total_len - hlen_prev[WORD_W-1:0];
    // Pad an odd final byte with a zero low byte
    assign sum_pad = seg_len[0] ? csum_add(i_snap.sum, {i_snap.hold, {BYTE_W{1'b0}}})
                                : i_snap.sum;
    assign total   = (WORD_W+3)'(sum_pad)
                   + (WORD_W+3)'(i_snap.src_addr[ADDR_W-1:WORD_W])
                   + (WORD_W+3)'(i_snap.src_addr[WORD_W-1:0])
                   + (WORD_W+3)'(i_snap.dst_addr[ADDR_W-1:WORD_W])
                   + (WORD_W+3)'(i_snap.dst_addr[WORD_W-1:0])
                   + (WORD_W+3)'(i_snap.proto)
                   + (WORD_W+3)'(seg_len);
    assign fold1   = (WORD_W+1)'(total[WORD_W-1:0]) + (WORD_W+1)'(total[WORD_W+2:WORD_W]);
    assign fold2   = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);
    // UDP sends a computed zero as all ones
    assign csum    = (is_udp && fold2 == '1) ? '1 : ~fold2;
    assign offset  = WORD_W'(ip0) + hlen_prev[WORD_W-1:0]
                   + (is_tcp ? WORD_W'(TCP_CSUM_OFF) : WORD_W'(UDP_CSUM_OFF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_snap_ready) begin
            r_o_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_status <= status;
            r_o_value  <= (status == ST_OK) ? csum : '0;
            r_o_offset <= (status == ST_OK) ? offset : '0;
        end
    end

    assign o_result.valid           = r_o_valid;
    assign o_result.checksum_value  = r_o_value;
    assign o_result.checksum_offset = r_o_offset;
    assign o_result.result_status   = r_o_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_status != ST_OK |-> r_o_value == '0 && r_o_offset == '0)
        else $error("error result carries nonzero fields");

    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_o_valid)
        else $error("accepted snapshot did not reach output");

    a_udp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && status == ST_OK && is_udp |=> r_o_value != '0)
        else $error("UDP checksum sent as zero");

endmodule

FILE: hw/rtl/inner_l4_checksum_engine.sv
// Top level of the inner L4 checksum engine: parser and finishing stage.
//
//  channel   dir  handshake      payload
//  i_frame   in   valid/ready    frame_byte[7:0], frame_last
//  o_result  out  valid/ready    checksum_value[15:0], checksum_offset[15:0],
//                                result_status[2:0]
//  i_cfg     in   i_cfg_we       i_cfg_wdata[7:0] (headroom_bytes)
//
// One frame byte per cycle unless a last byte waits for the snapshot; each pair of
// segment bytes needs a single ones'-complement add. A frame's result passes the
// input register, frame snapshot and output register. Other bytes give no result.
// Reset clears the headroom to 0 and all frame state; no clearing pass.
// A stalled output holds the result and the snapshot behind it; non-last bytes
// keep flowing until a second last byte finds the snapshot occupied.
module inner_l4_checksum_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    l4cs_in_if.sink                         i_frame,
    l4cs_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [l4cs_pkg::HEADROOM_W-1:0] i_cfg_wdata
);
    import l4cs_pkg::*;

    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    l4cs_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (i_frame),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    l4cs_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_result     (o_result)
    );

endmodule
